@@ sv/fird_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fird_pkg
// Shared types and constants for the flash image record decoder.
// ----------------------------------------------------------------------------
package fird_pkg;

    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 16;

    localparam logic [CIDX_W-1:0] CFG_PATCH_ADDR   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PATCH_FIRST  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PATCH_SECOND = 2'd2;

    localparam logic [ADDR_W-1:0] PATCH_ADDR_RST   = 16'hFFFE;
    localparam logic [BYTE_W-1:0] PATCH_FIRST_RST  = 8'hFA;
    localparam logic [BYTE_W-1:0] PATCH_SECOND_RST = 8'h7B;

    typedef struct packed {
        logic [ADDR_W-1:0] patch_address;
        logic [BYTE_W-1:0] patch_first_byte;
        logic [BYTE_W-1:0] patch_second_byte;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0] write_data;
        logic              was_patched;
    } result_t;

endpackage

@@ sv/fird_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fird_cfg
// Patch configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module fird_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fird_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [fird_pkg::CDATA_W-1:0]   cfg_data,
    output fird_pkg::cfg_t                 cfg
);
    import fird_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.patch_address     <= PATCH_ADDR_RST;
            cfg_reg.patch_first_byte  <= PATCH_FIRST_RST;
            cfg_reg.patch_second_byte <= PATCH_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATCH_ADDR:   cfg_reg.patch_address     <= cfg_data[ADDR_W-1:0];
                CFG_PATCH_FIRST:  cfg_reg.patch_first_byte  <= cfg_data[BYTE_W-1:0];
                CFG_PATCH_SECOND: cfg_reg.patch_second_byte <= cfg_data[BYTE_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/fird_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fird_parser
// Record phase machine; builds one program request per data byte.
// ----------------------------------------------------------------------------
module fird_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [fird_pkg::BYTE_W-1:0]  stream_byte,
    input  logic                         image_start,
    input  fird_pkg::cfg_t               cfg,
    output fird_pkg::result_t            result
);
    import fird_pkg::*;

    localparam logic [2:0] PH_COUNT = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_ADRH  = 3'd2;
    localparam logic [2:0] PH_ADRL  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    logic [2:0]        phase_reg,   phase_next;
    logic [BYTE_W-1:0] left_reg,    left_next;
    logic [ADDR_W-1:0] addr_reg,    addr_next;
    logic [BYTE_W-1:0] count_reg,   count_next;
    logic              patch_reg,   patch_next;
    logic [ADDR_W-1:0] addr_full;
    logic [BYTE_W-1:0] left_dec;

    always_comb
    begin
        phase_next    = phase_reg;
        left_next     = left_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        patch_next    = patch_reg;
        addr_full     = addr_reg | {{(ADDR_W-BYTE_W){1'b0}}, stream_byte};
        left_dec      = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
        result        = '0;
        result.write_address = addr_reg;
        result.write_data    = stream_byte;
        if (image_start || phase_reg == PH_COUNT)
        begin
            phase_next = PH_LEN;
            left_next  = '0;
            count_next = '0;
            patch_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_ADRH:
                begin
                    addr_next  = {stream_byte, {(ADDR_W-BYTE_W){1'b0}}};
                    phase_next = PH_ADRL;
                end
                PH_ADRL:
                begin
                    addr_next  = addr_full;
                    patch_next = (addr_full == cfg.patch_address);
                    count_next = '0;
                    phase_next = (left_reg != '0) ? PH_DATA : PH_LEN;
                end
                PH_DATA:
                begin
                    result.valid = 1'b1;
                    if (patch_reg && count_reg == 8'd0)
                    begin
                        result.write_data  = cfg.patch_first_byte;
                        result.was_patched = 1'b1;
                    end
                    else if (patch_reg && count_reg == 8'd1)
                    begin
                        result.write_data  = cfg.patch_second_byte;
                        result.was_patched = 1'b1;
                    end
                    addr_next  = addr_reg + 1'b1;
                    count_next = (count_reg != 8'hFF) ? count_reg + 1'b1 : count_reg;
                    left_next  = left_dec;
                    if (left_dec == '0)
                        phase_next = PH_LEN;
                end
                default:
                begin
                    left_next  = (stream_byte > 8'd3) ? stream_byte - 8'd3 : '0;
                    phase_next = PH_ADRH;
                end
            endcase
        end
        result.valid = result.valid & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT;
            left_reg  <= '0;
            addr_reg  <= '0;
            count_reg <= '0;
            patch_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            patch_reg <= patch_next;
        end
    end

endmodule

@@ sv/fird_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fird_out_reg
// Result register on the master side; holds a word until it is taken.
// ----------------------------------------------------------------------------
module fird_out_reg
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  fird_pkg::result_t                             result,
    output logic                                          load_ok,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [fird_pkg::ADDR_W+fird_pkg::BYTE_W-1:0]  m_tdata,
    output logic                                          m_tuser
);
    import fird_pkg::*;

    logic                     valid_reg;
    logic [ADDR_W+BYTE_W-1:0] data_reg;
    logic                     user_reg;

    assign load_ok = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ok)
            valid_reg <= result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && result.valid)
        begin
            data_reg <= {result.write_data, result.write_address};
            user_reg <= result.was_patched;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

@@ sv/flash_image_record_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_image_record_decoder_top
// Firmware image byte parser emitting one flash program request per data byte.
// The request for an accepted data byte shows on m_tvalid in the cycle after it.
// Throughput: one byte per cycle; the result register stalls input only while
// it holds a word that the sink has not taken.
// Reset: rst_n clears the parser to await a vector count byte and loads the
// patch registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module flash_image_record_decoder_top
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [fird_pkg::BYTE_W-1:0]                   s_tdata,  // [7:0] stream_byte
    input  logic                                          s_tuser,  // [0] image_start
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // [15:0] write_address, [23:16] write_data
    output logic [fird_pkg::ADDR_W+fird_pkg::BYTE_W-1:0]  m_tdata,
    output logic                                          m_tuser,  // [0] was_patched
    input  logic                                          cfg_we,
    input  logic [fird_pkg::CIDX_W-1:0]                   cfg_index,
    input  logic [fird_pkg::CDATA_W-1:0]                  cfg_data
);
    import fird_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    load_ok;
    logic    s_accept;

    assign s_tready = load_ok;
    assign s_accept = s_tvalid && load_ok;

    fird_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fird_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .stream_byte (s_tdata),
        .image_start (s_tuser),
        .cfg         (cfg),
        .result      (result)
    );

    fird_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser) |-> !result.valid)
        else $error("request produced on an image start byte");

    a_result_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> s_accept)
        else $error("request produced without an accepted byte");

    a_patch_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.was_patched) |->
            (result.write_data == cfg.patch_first_byte ||
             result.write_data == cfg.patch_second_byte))
        else $error("patched byte differs from patch registers");

    a_loaded_word_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && load_ok) |=>
            (m_tvalid && m_tdata == $past({result.write_data, result.write_address})))
        else $error("request not presented after load");
`endif

endmodule
